[hw/rtl/bmxt_pkg.sv]
// ----------------------------------------------------------------------------
// bmxt_pkg
// Word types, status codes and controller/datapath signal groups for the
// bounded max-xor trie.
// ----------------------------------------------------------------------------
package bmxt_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key_value;
        logic [31:0] upper_limit;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] best_xor;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
    } ctl_cmd_t;

    typedef struct packed {
        logic reject;
        logic walk_end;
    } dp_stat_t;

endpackage

[hw/rtl/bmxt_ctrl.sv]
// ----------------------------------------------------------------------------
// bmxt_ctrl
// Sequencer: takes a request word, runs the trie walk one level per cycle,
// then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module bmxt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bmxt_pkg::ctl_cmd_t cmd,
    input  bmxt_pkg::dp_stat_t stat
);
    import bmxt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.reject ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result never overwrites a word still waiting downstream
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result pushed over pending word");

    a_reject_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && stat.reject) |=> (state_reg == S_DONE))
        else $error("rejected insert entered walk");

    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && !stat.walk_end) |=> (state_reg == S_WALK && req_stall))
        else $error("walk left early");

endmodule

[hw/rtl/bmxt_dpath.sv]
// ----------------------------------------------------------------------------
// bmxt_dpath
// Trie datapath: node table, root links, walk registers and result/output
// registers. A node entry holds both child links and both child minimums,
// so one registered read per level serves insert and query alike.
// ----------------------------------------------------------------------------
module bmxt_dpath
#(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bmxt_pkg::ctl_cmd_t  cmd,
    output bmxt_pkg::dp_stat_t  stat,
    input  bmxt_pkg::in_word_t  req_word,
    output bmxt_pkg::out_word_t rsp_word
);
    import bmxt_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int LVL_W = $clog2(KEY_BITS);
    localparam int CMP_W = (KEY_BITS > 32) ? KEY_BITS : 32;
    localparam int ENT_W = 2 * IDX_W + 2 * KEY_BITS;

    localparam logic [LVL_W-1:0] LVL_TOP   = LVL_W'(KEY_BITS - 1);
    localparam logic [CNT_W-1:0] NODES_CNT = CNT_W'(NODE_COUNT);
    localparam logic [CNT_W-1:0] KEYS_CNT  = CNT_W'(KEY_BITS);

    logic [ENT_W-1:0] mem [NODE_COUNT];
    logic [ENT_W-1:0] rd_data_reg;

    logic                type_reg,   type_next;
    logic [KEY_BITS-1:0] key_reg,    key_next;
    logic [31:0]         limit_reg,  limit_next;
    logic [LVL_W-1:0]    level_reg,  level_next;
    logic [IDX_W-1:0]    node_reg,   node_next;
    logic                first_reg,  first_next;
    logic                fresh_reg,  fresh_next;
    logic [KEY_BITS-1:0] best_reg,   best_next;
    logic [CNT_W-1:0]    used_reg,   used_next;
    out_word_t           res_reg,    res_next;
    out_word_t           out_reg,    out_next;
    logic [IDX_W-1:0]    root_link_reg [2];
    logic [IDX_W-1:0]    root_link_next [2];
    logic [KEY_BITS-1:0] root_min_reg [2];
    logic [KEY_BITS-1:0] root_min_next [2];

    logic [CMP_W-1:0]    key_ext;
    logic [KEY_BITS-1:0] key_in;
    logic                full;
    logic [IDX_W-1:0]    cur_link [2];
    logic [KEY_BITS-1:0] cur_min [2];
    logic [IDX_W-1:0]    new_link [2];
    logic [KEY_BITS-1:0] new_min [2];
    logic                kbit;
    logic                pref_ok;
    logic                same_ok;
    logic                alloc;
    logic [IDX_W-1:0]    child;
    logic [KEY_BITS-1:0] best_step;
    logic [CMP_W-1:0]    best_ext;
    logic                mem_we;
    logic [ENT_W-1:0]    mem_wdata;

    assign key_ext = CMP_W'(req_word.key_value);
    assign key_in  = key_ext[KEY_BITS-1:0];
    assign full    = (NODES_CNT - used_reg) < KEYS_CNT;

    assign stat.reject = (req_word.req_type == REQ_INSERT) && full;

    // current node entry: root registers, a node just allocated, or table data
    always_comb
    begin
        if (first_reg)
        begin
            cur_link = root_link_reg;
            cur_min  = root_min_reg;
        end
        else if (fresh_reg)
        begin
            cur_link[0] = '0;
            cur_link[1] = '0;
            cur_min[0]  = '0;
            cur_min[1]  = '0;
        end
        else
        begin
            cur_link[0] = rd_data_reg[IDX_W-1:0];
            cur_link[1] = rd_data_reg[2*IDX_W-1:IDX_W];
            cur_min[0]  = rd_data_reg[2*IDX_W+KEY_BITS-1:2*IDX_W];
            cur_min[1]  = rd_data_reg[ENT_W-1:2*IDX_W+KEY_BITS];
        end
    end

    assign kbit    = key_reg[level_reg];
    assign pref_ok = (cur_link[~kbit] != '0) &&
                     (CMP_W'(cur_min[~kbit]) <= CMP_W'(limit_reg));
    assign same_ok = (cur_link[kbit] != '0) &&
                     (CMP_W'(cur_min[kbit]) <= CMP_W'(limit_reg));
    assign alloc   = (cur_link[kbit] == '0);

    always_comb
    begin
        best_step            = best_reg;
        best_step[level_reg] = pref_ok;
    end
    assign best_ext = CMP_W'(best_step);

    assign stat.walk_end = (level_reg == '0) ||
                           ((type_reg == REQ_QUERY) && !pref_ok && !same_ok);

    always_comb
    begin
        type_next      = type_reg;
        key_next       = key_reg;
        limit_next     = limit_reg;
        level_next     = level_reg;
        node_next      = node_reg;
        first_next     = first_reg;
        fresh_next     = fresh_reg;
        best_next      = best_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        root_link_next = root_link_reg;
        root_min_next  = root_min_reg;
        new_link       = cur_link;
        new_min        = cur_min;
        child          = cur_link[kbit];
        mem_we         = 1'b0;
        mem_wdata      = {new_min[1], new_min[0], new_link[1], new_link[0]};

        if (cmd.load)
        begin
            type_next  = req_word.req_type;
            key_next   = key_in;
            limit_next = req_word.upper_limit;
            level_next = LVL_TOP;
            node_next  = '0;
            first_next = 1'b1;
            fresh_next = 1'b0;
            best_next  = '0;
            if (stat.reject)
            begin
                res_next = '{status: ST_FULL, best_xor: 32'd0};
            end
        end

        if (cmd.step)
        begin
            level_next = level_reg - 1'b1;
            first_next = 1'b0;
            if (type_reg == REQ_INSERT)
            begin
                if (alloc)
                begin
                    child       = used_reg[IDX_W-1:0];
                    new_min[kbit] = key_reg;
                    used_next   = used_reg + 1'b1;
                end
                else if (key_reg < cur_min[kbit])
                begin
                    new_min[kbit] = key_reg;
                end
                new_link[kbit] = child;
                mem_wdata      = {new_min[1], new_min[0], new_link[1], new_link[0]};
                if (first_reg)
                begin
                    root_link_next = new_link;
                    root_min_next  = new_min;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                node_next  = child;
                fresh_next = alloc;
                if (level_reg == '0)
                begin
                    res_next = '{status: ST_INSERTED, best_xor: 32'd0};
                end
            end
            else
            begin
                fresh_next = 1'b0;
                best_next  = best_step;
                node_next  = pref_ok ? cur_link[~kbit] : cur_link[kbit];
                if (!pref_ok && !same_ok)
                begin
                    res_next = '{status: ST_NONE, best_xor: 32'd0};
                end
                else if (level_reg == '0)
                begin
                    res_next = '{status: ST_FOUND, best_xor: best_ext[31:0]};
                end
            end
        end

        if (cmd.push)
        begin
            out_next = res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[node_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[node_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= CNT_W'(1);
            root_link_reg[0] <= '0;
            root_link_reg[1] <= '0;
            first_reg        <= 1'b1;
            fresh_reg        <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            root_link_reg <= root_link_next;
            first_reg     <= first_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        key_reg      <= key_next;
        limit_reg    <= limit_next;
        level_reg    <= level_next;
        node_reg     <= node_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        root_min_reg <= root_min_next;
    end

    assign rsp_word = out_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) && (used_reg <= NODES_CNT))
        else $error("node count out of range");

    a_query_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && type_reg == REQ_QUERY) |=> $stable(used_reg))
        else $error("query changed node count");

endmodule

[hw/rtl/bounded_max_xor_trie.sv]
// ----------------------------------------------------------------------------
// bounded_max_xor_trie
// Binary trie of unsigned keys answering "max key xor value over stored keys
// no greater than a limit"; inserts and queries share one walk sequencer.
// ----------------------------------------------------------------------------
//   channel   handshake             word
//   req       req_valid/req_stall   req_type, key_value, upper_limit
//   rsp       rsp_valid/rsp_stall   status, best_xor
//
// Sequence: accept, one trie level per cycle, hand-off to the output register;
//   a rejected insert skips the walk. The level loop is set by the node table's
//   single registered read. A query with no partner ends at the failing level.
// Reset: root links cleared, one node in use; node table is not cleared.
// Stalls: a finished result waits in the output register while the next
//   request is accepted and walked.
// ----------------------------------------------------------------------------
module bounded_max_xor_trie
#(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bmxt_pkg::in_word_t  req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bmxt_pkg::out_word_t rsp_word
);
    import bmxt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    bmxt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    bmxt_dpath
    #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_word (req_word),
        .rsp_word (rsp_word)
    );

endmodule
